FILE: design/lfu_page_replacement_macros.svh
// Assertion macros for the LFU page replacement block.
// Include in modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef LFU_PAGE_REPLACEMENT_MACROS_SVH
`define LFU_PAGE_REPLACEMENT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LFU_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define LFU_NEVER(label, cond, msg) \
    `LFU_CHECK(label, !(cond), msg)

`endif

FILE: design/lfu_pkg.sv
// Shared types and constants for the LFU page replacement block.
// No dependencies; imported by every module of the block.
`default_nettype none

package lfu_pkg;

    localparam int NUM_FRAMES = 8;
    localparam int PAGE_BITS  = 16;
    localparam int COUNT_BITS = 16;
    localparam int FRAME_BITS = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int FAULT_BITS = 32;
    localparam int CFG_BITS   = 4;
    localparam int IDX_BITS   = 3;

    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(8);

    typedef struct packed {
        logic [PAGE_BITS-1:0]  page;
        logic [COUNT_BITS-1:0] count;
    } entry_t;

    typedef struct packed {
        logic                  en;
        logic [FRAME_BITS-1:0] addr;
    } ram_rd_t;

    typedef struct packed {
        logic                  en;
        logic [FRAME_BITS-1:0] addr;
        entry_t                data;
    } ram_wr_t;

    typedef struct packed {
        logic                  hit;
        logic [IDX_BITS-1:0]   frame_index;
        logic [FAULT_BITS-1:0] fault_count;
    } res_t;

endpackage

`default_nettype wire

FILE: design/lfu_frame_ram.sv
// Frame table memory: page number and use count per frame.
// One write port, one read port with registered data. Depends on lfu_pkg.
`default_nettype none

module lfu_frame_ram (
    input  wire logic            clk,
    input  wire lfu_pkg::ram_wr_t wr,
    input  wire lfu_pkg::ram_rd_t rd,
    output lfu_pkg::entry_t      rd_data
);
    import lfu_pkg::*;

    entry_t mem [NUM_FRAMES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: design/lfu_ctrl.sv
// Lookup and replacement sequencer: scans the frame table, picks hit or victim,
// writes the entry back and keeps valid bits and the fault total. Depends on lfu_pkg.
`default_nettype none
`include "lfu_page_replacement_macros.svh"

module lfu_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [lfu_pkg::PAGE_BITS-1:0]  page,
    input  wire logic [lfu_pkg::FRAME_BITS-1:0] last_idx,
    output lfu_pkg::ram_rd_t                    rd,
    output lfu_pkg::ram_wr_t                    wr,
    input  wire lfu_pkg::entry_t                rd_data,
    output logic                                res_valid,
    input  wire logic                           res_take,
    output lfu_pkg::res_t                       res
);
    import lfu_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_HOLD   = 2'd3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [FAULT_BITS-1:0] FAULT_MAX = '1;

    logic [1:0]            state_reg, state_next;
    logic [FRAME_BITS-1:0] cmp_idx_reg, cmp_idx_next;
    logic [PAGE_BITS-1:0]  page_reg, page_next;
    logic                  found_reg, found_next;
    logic [FRAME_BITS-1:0] match_idx_reg, match_idx_next;
    logic [COUNT_BITS-1:0] match_cnt_reg, match_cnt_next;
    logic [FRAME_BITS-1:0] best_idx_reg, best_idx_next;
    logic [COUNT_BITS-1:0] best_cnt_reg, best_cnt_next;
    logic [NUM_FRAMES-1:0] valid_reg, valid_next;
    logic [FAULT_BITS-1:0] fault_reg, fault_next;
    res_t                  res_reg, res_next;

    logic                  accept;
    logic                  slot_valid;
    logic [COUNT_BITS-1:0] eff_cnt;
    logic                  is_match;
    logic                  first;
    logic [COUNT_BITS-1:0] hit_cnt;
    logic [FAULT_BITS-1:0] fault_inc;

    assign accept   = (state_reg == ST_IDLE) && in_valid;
    assign in_stall = (state_reg != ST_IDLE);

    // Entry under compare: invalid frames count as zero and never match.
    assign slot_valid = valid_reg[cmp_idx_reg];
    assign eff_cnt    = slot_valid ? rd_data.count : '0;
    assign is_match   = slot_valid && (rd_data.page == page_reg);
    assign first      = (cmp_idx_reg == '0);

    assign hit_cnt   = (match_cnt_reg == COUNT_MAX) ? match_cnt_reg
                                                   : COUNT_BITS'(match_cnt_reg + 1'b1);
    assign fault_inc = (fault_reg == FAULT_MAX) ? fault_reg
                                                : FAULT_BITS'(fault_reg + 1'b1);

    always_comb
    begin
        state_next     = state_reg;
        cmp_idx_next   = cmp_idx_reg;
        page_next      = page_reg;
        found_next     = found_reg;
        match_idx_next = match_idx_reg;
        match_cnt_next = match_cnt_reg;
        best_idx_next  = best_idx_reg;
        best_cnt_next  = best_cnt_reg;
        valid_next     = valid_reg;
        fault_next     = fault_reg;
        res_next       = res_reg;
        rd.en          = 1'b0;
        rd.addr        = FRAME_BITS'(cmp_idx_reg + 1'b1);
        wr.en          = 1'b0;
        wr.addr        = best_idx_reg;
        wr.data.page   = page_reg;
        wr.data.count  = COUNT_BITS'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                rd.addr = '0;
                if (accept)
                begin
                    rd.en        = 1'b1;
                    page_next    = page;
                    cmp_idx_next = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Keep the lowest matching frame.
                if (is_match && (first || !found_reg))
                begin
                    match_idx_next = cmp_idx_reg;
                    match_cnt_next = rd_data.count;
                end
                found_next = first ? is_match : (found_reg || is_match);
                // Strict less-than leaves ties at the lower index.
                if (first || (eff_cnt < best_cnt_reg))
                begin
                    best_idx_next = cmp_idx_reg;
                    best_cnt_next = eff_cnt;
                end
                if (cmp_idx_reg == last_idx)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    rd.en        = 1'b1;
                    cmp_idx_next = FRAME_BITS'(cmp_idx_reg + 1'b1);
                end
            end
            ST_UPDATE:
            begin
                wr.en = 1'b1;
                if (found_reg)
                begin
                    wr.addr       = match_idx_reg;
                    wr.data.count = hit_cnt;
                    res_next.hit         = 1'b1;
                    res_next.frame_index = IDX_BITS'(match_idx_reg);
                    res_next.fault_count = fault_reg;
                end
                else
                begin
                    valid_next[best_idx_reg] = 1'b1;
                    fault_next               = fault_inc;
                    res_next.hit         = 1'b0;
                    res_next.frame_index = IDX_BITS'(best_idx_reg);
                    res_next.fault_count = fault_inc;
                end
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            fault_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            fault_reg <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        page_reg      <= page_next;
        found_reg     <= found_next;
        match_idx_reg <= match_idx_next;
        match_cnt_reg <= match_cnt_next;
        best_idx_reg  <= best_idx_next;
        best_cnt_reg  <= best_cnt_next;
        res_reg       <= res_next;
    end

    assign res_valid = (state_reg == ST_HOLD);
    assign res       = res_reg;

    `LFU_CHECK(a_hold_stable, (state_reg == ST_HOLD && !res_take) |=> (state_reg == ST_HOLD && $stable(res_reg)), "result changed while held")
    `LFU_CHECK(a_fill_valid, (state_reg == ST_UPDATE && !found_reg) |=> valid_reg[$past(best_idx_reg)], "replaced frame not marked valid")
    `LFU_NEVER(a_scan_range, (state_reg == ST_SCAN) && (cmp_idx_reg > last_idx), "scan ran past the last frame in use")
    `LFU_CHECK(a_fault_mono, 1'b1 |=> (fault_reg >= $past(fault_reg)), "fault total went down")

endmodule

`default_nettype wire

FILE: design/lfu_page_replacement.sv
// LFU page replacement unit: top level with the frame count register and result register.
// Depends on lfu_pkg, lfu_frame_ram and lfu_ctrl.
//
//  port group    direction  handshake           payload
//  ------------  ---------  ------------------  -------------------------------
//  input word    in         in_valid/in_stall   page[15:0]
//  result word   out        out_valid/out_stall hit, frame_index[2:0], fault_count[31:0]
//  config write  in         cfg_valid/cfg_ready cfg_data[3:0] -> frames_in_use
//
// From acceptance to a result in the output register, a reference takes one frame table
// read per cycle over the single read port, one for each frame in use, then a write-back
// step and a hand-off step; the next reference is accepted only after the hand-off, so
// one reference is finished before the next one starts.
// Reset clears every valid bit and the fault total and sets frames_in_use to 8; the frame
// table itself needs no clearing pass. A stalled result waits in the output register
// while the next reference is already accepted and scanned.
`default_nettype none

module lfu_page_replacement (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [lfu_pkg::PAGE_BITS-1:0]  page,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                hit,
    output logic [lfu_pkg::IDX_BITS-1:0]        frame_index,
    output logic [lfu_pkg::FAULT_BITS-1:0]      fault_count,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lfu_pkg::CFG_BITS-1:0]   cfg_data
);
    import lfu_pkg::*;

    localparam logic [CFG_BITS-1:0] CFG_MAX = CFG_BITS'(NUM_FRAMES);

    logic [CFG_BITS-1:0]   frames_reg, frames_next;
    logic [CFG_BITS-1:0]   frames_m1;
    logic [FRAME_BITS-1:0] last_idx;

    logic                  out_valid_reg, out_valid_next;
    res_t                  out_reg, out_next;
    logic                  out_free;

    ram_rd_t               rd;
    ram_wr_t               wr;
    entry_t                rd_data;
    logic                  res_valid;
    res_t                  res;

    // Config writes land only while the sequencer is idle.
    assign cfg_ready   = !in_stall;
    assign frames_next = (cfg_valid && cfg_ready) ? cfg_data : frames_reg;

    // Clamp the frame count: zero acts as one, anything above the table acts as full.
    assign frames_m1 = CFG_BITS'(frames_reg - 1'b1);
    always_comb
    begin
        priority if (frames_reg == '0)
        begin
            last_idx = '0;
        end
        else if (frames_reg > CFG_MAX)
        begin
            last_idx = FRAME_BITS'(NUM_FRAMES - 1);
        end
        else
        begin
            last_idx = frames_m1[FRAME_BITS-1:0];
        end
    end

    // Output register: refill as it drains; the sequencer holds its result while a stalled one occupies it.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg    <= CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            frames_reg    <= frames_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid   = out_valid_reg;
    assign hit         = out_reg.hit;
    assign frame_index = out_reg.frame_index;
    assign fault_count = out_reg.fault_count;

    lfu_frame_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    lfu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .page      (page),
        .last_idx  (last_idx),
        .rd        (rd),
        .wr        (wr),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_take  (out_free),
        .res       (res)
    );

endmodule

`default_nettype wire
